/* design/lkvt_pkg.sv */
// ---------------------------------------------------------------------------
// lkvt_pkg
// shared sizes and codes for the linear key/value table
// ---------------------------------------------------------------------------
package lkvt_pkg;

	// table depth and derived index widths
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// payload widths
	localparam int CMD_W = 3;
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int STS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CONTAINS  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INCREMENT = 3'd4;

	// status codes
	localparam logic [STS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STS_W-1:0] ST_MISSING = 2'd2;

endpackage

/* design/lkvt_ram.sv */
// ---------------------------------------------------------------------------
// lkvt_ram
// generic single-clock ram, one write port and one registered read port
// ---------------------------------------------------------------------------
module lkvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/linear_key_value_table_core.sv */
// sequence: the start transfer leads to a scan of the n stored entries, then an
//   exec step that raises done; a remove that moves the last entry adds a move read and a move write step
// one request at a time: a new start is taken only while idle; the scan runs
//   one entry per cycle through the key ram read port
// reset: arst_n clears the entry count and the sequencer; the rams are not cleared
// busy drops in the cycle of the done strobe, so the next start can overlap it
// ---------------------------------------------------------------------------
// linear_key_value_table_core
// densely packed key/value table with linear search, held in two rams
// ---------------------------------------------------------------------------
module linear_key_value_table_core import lkvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] command,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	output logic             done,
	output logic [VAL_W-1:0] read_value,
	output logic             found,
	output logic [STS_W-1:0] status
);

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_EXEC    = 3'd2;
	localparam logic [2:0] S_MOVE_RD = 3'd3;
	localparam logic [2:0] S_MOVE_WR = 3'd4;

	logic [2:0]       state_q;

	// latched request
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// table occupancy
	logic [CNT_W-1:0] count_q;

	// scan pointer and the compare stage, which checks the registered ram read of the slot issued the cycle before
	logic [CNT_W-1:0] scan_idx_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// lookup outcome
	logic             hit_q;
	logic [IDX_W-1:0] slot_q;
	logic [VAL_W-1:0] hit_value_q;

	// result registers
	logic             done_q;
	logic [VAL_W-1:0] res_value_q;
	logic             res_found_q;
	logic [STS_W-1:0] res_status_q;

	// ram ports, both rams share addresses
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic [KEY_W-1:0] key_wdata;
	logic [VAL_W-1:0] val_wdata;
	logic [KEY_W-1:0] key_rdata;
	logic [VAL_W-1:0] val_rdata;

	// datapath terms
	logic             key_match;
	logic             scan_more;
	logic             table_full;
	logic [CNT_W-1:0] count_m1;
	logic [VAL_W-1:0] inc_sum;
	logic [VAL_W-1:0] store_data;
	logic             do_store;

	// the key read out of the ram belongs to the slot issued last cycle
	assign key_match  = cmp_valid_s1 && (key_rdata == key_q);
	assign scan_more  = scan_idx_q < count_q;
	assign table_full = count_q >= CNT_W'(ENTRIES);
	assign count_m1   = count_q - CNT_W'(1);

	// increment treats an absent key as zero, wraps at 64 bits
	assign inc_sum    = (hit_q ? hit_value_q : '0) + value_q;
	assign store_data = (cmd_q == CMD_INCREMENT) ? inc_sum : value_q;

	// set or increment writes in place on a hit, appends on a miss if room
	assign do_store = (state_q == S_EXEC)
		&& ((cmd_q == CMD_SET) || (cmd_q == CMD_INCREMENT))
		&& (hit_q || !table_full);

	// remove: count is already decremented when the last entry is read
	assign rd_addr = (state_q == S_MOVE_RD) ? count_q[IDX_W-1:0] : scan_idx_q[IDX_W-1:0];

	always_comb begin
		wr_en     = do_store || (state_q == S_MOVE_WR);
		wr_addr   = hit_q ? slot_q : count_q[IDX_W-1:0];
		key_wdata = key_q;
		val_wdata = store_data;
		if (state_q == S_MOVE_WR) begin
			// last entry fills the freed slot
			wr_addr   = slot_q;
			key_wdata = key_rdata;
			val_wdata = val_rdata;
		end
	end

	lkvt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (key_wdata),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lkvt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (ENTRIES)
	) u_val_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (val_wdata),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_idx_q   <= '0;
						cmp_valid_s1 <= 1'b0;
						hit_q        <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (key_match) begin
						// keys are unique, first match ends the scan
						hit_q   <= 1'b1;
						state_q <= S_EXEC;
					end else if (scan_more) begin
						cmp_valid_s1 <= 1'b1;
						scan_idx_q   <= scan_idx_q + CNT_W'(1);
					end else begin
						// every stored slot compared, key absent
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					case (cmd_q)
						CMD_SET, CMD_INCREMENT: begin
							if (!hit_q && !table_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						CMD_REMOVE: begin
							if (hit_q) begin
								count_q <= count_m1;
								if (CNT_W'(slot_q) < count_m1) begin
									done_q  <= 1'b0;
									state_q <= S_MOVE_RD;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, lookup and result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			cmd_q   <= command;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_SCAN) begin
			if (key_match) begin
				slot_q      <= cmp_idx_s1;
				hit_value_q <= val_rdata;
			end else if (scan_more) begin
				cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
			end
		end
		if (state_q == S_EXEC) begin
			res_value_q  <= '0;
			res_found_q  <= hit_q;
			res_status_q <= ST_OK;
			case (cmd_q)
				CMD_SET: begin
					if (!hit_q && table_full) begin
						res_status_q <= ST_FULL;
					end
				end
				CMD_GET: begin
					if (hit_q) begin
						res_value_q <= hit_value_q;
					end else begin
						res_status_q <= ST_MISSING;
					end
				end
				CMD_REMOVE: begin
					if (!hit_q) begin
						res_status_q <= ST_MISSING;
					end
				end
				CMD_CONTAINS: begin
				end
				CMD_INCREMENT: begin
					if (hit_q || !table_full) begin
						res_value_q <= inc_sum;
					end else begin
						res_status_q <= ST_FULL;
					end
				end
				default: begin
					// unused codes: no change, all-zero reply
					res_found_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign read_value = res_value_q;
	assign found      = res_found_q;
	assign status     = res_status_q;

endmodule

/* tb/tb_linear_key_value_table_core.sv */
// ---------------------------------------------------------------------------
// tb_linear_key_value_table_core
// self-checking bench for the linear key/value table: a shadow copy of the
// table predicts every reply, a monitor compares each done strobe with the
// oldest prediction; directed corner requests first, then random requests
// drawn from a key pool in alternating grow and shrink phases
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_linear_key_value_table_core;
	import lkvt_pkg::*;

	// one expected reply per accepted request
	typedef struct {
		logic [VAL_W-1:0] read_value;
		logic             found;
		logic [STS_W-1:0] status;
	} kv_reply_t;

	// shadow of the table contents, kept packed the same way as the block
	class kv_shadow;
		logic [KEY_W-1:0] keys [ENTRIES];
		logic [VAL_W-1:0] vals [ENTRIES];
		int               used;
		kv_reply_t        replies_due [$];
		int               errors;

		function new();
			used   = 0;
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// apply one accepted request to the shadow and queue its reply
		function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
			kv_reply_t        r;
			int               slot;
			logic [VAL_W-1:0] sum;
			slot = -1;
			for (int i = 0; i < used; i++)
				if (slot < 0 && keys[i] == k)
					slot = i;
			r.read_value = '0;
			r.found      = (slot >= 0);
			r.status     = ST_OK;
			case (cmd)
				CMD_SET: begin
					if (slot >= 0)
						vals[slot] = v;
					else if (used == ENTRIES)
						r.status = ST_FULL;
					else begin
						keys[used] = k;
						vals[used] = v;
						used++;
					end
				end
				CMD_GET: begin
					if (slot >= 0)
						r.read_value = vals[slot];
					else
						r.status = ST_MISSING;
				end
				CMD_REMOVE: begin
					// last entry fills the hole
					if (slot >= 0) begin
						used--;
						keys[slot] = keys[used];
						vals[slot] = vals[used];
					end else
						r.status = ST_MISSING;
				end
				CMD_CONTAINS: begin
				end
				CMD_INCREMENT: begin
					// absent key counts as zero, sum wraps at 64 bits
					sum = ((slot >= 0) ? vals[slot] : '0) + v;
					if (slot >= 0) begin
						vals[slot]   = sum;
						r.read_value = sum;
					end else if (used == ENTRIES)
						r.status = ST_FULL;
					else begin
						keys[used]   = k;
						vals[used]   = sum;
						used++;
						r.read_value = sum;
					end
				end
				default: begin
					// unused codes: no change, all-zero reply
					r.found = 1'b0;
				end
			endcase
			replies_due.push_back(r);
		endfunction

		task check_reply(logic [VAL_W-1:0] rv, logic f, logic [STS_W-1:0] s);
			kv_reply_t want;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with none due: value %h found %b status %0d",
					rv, f, s));
				return;
			end
			want = replies_due.pop_front();
			if (rv !== want.read_value)
				report_mismatch($sformatf("read_value %h, want %h", rv, want.read_value));
			if (f !== want.found)
				report_mismatch($sformatf("found %b, want %b", f, want.found));
			if (s !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", s, want.status));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [CMD_W-1:0] command = CMD_SET;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] value = '0;
	logic             busy;
	logic             done;
	logic [VAL_W-1:0] read_value;
	logic             found;
	logic [STS_W-1:0] status;

	kv_shadow         shadow;
	logic [KEY_W-1:0] key_pool [96];

	linear_key_value_table_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.key        (key),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.found      (found),
		.status     (status)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

	// monitor: values read here are the ones from just before the edge,
	// so a reply and a new request in the same cycle are both seen cleanly
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				shadow.check_reply(read_value, found, status);
			if (start === 1'b1 && busy === 1'b0)
				shadow.note_request(command, key, value);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// present a request and hold it until the transfer edge; start is left
	// high so a burst can follow without a drop
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
		logic [VAL_W-1:0] v);
		start   <= 1'b1;
		command <= cmd;
		key     <= k;
		value   <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic go_idle(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int               burst_left;
		int               pick;
		bit               growing;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;

		shadow = new();

		// key pool: the extremes, single-bit keys that differ from each other
		// in two places, and random keys; more keys than slots so the table fills
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 0; i < 16; i++)
			key_pool[2 + i] = 64'h1 << (i * 4 + 3);
		for (int i = 18; i < 96; i++)
			key_pool[i] = rand64();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners on an empty, then lightly filled table
		send_request(CMD_CONTAINS,  '0, '0);
		send_request(CMD_GET,       '1, '1);
		send_request(CMD_REMOVE,    '1, '0);
		send_request(CMD_INCREMENT, 64'h0123_4567_89ab_cdef, '1);
		send_request(CMD_SET,       '0, '1);
		send_request(CMD_SET,       '1, '0);
		send_request(CMD_GET,       '0, '0);
		send_request(CMD_INCREMENT, '0, 64'd1);
		go_idle(4);
		send_request(CMD_GET,       '0, '0);
		send_request(CMD_INCREMENT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(CMD_SET,       '1, 64'h1234_5678);
		send_request(CMD_CONTAINS,  '1, '0);
		send_request(CMD_GET,       '1, '0);
		send_request(CMD_INCREMENT, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5556);
		send_request(CMD_CONTAINS,  64'h5555_5555_5555_5554, '0);
		send_request(3'(CMD_INCREMENT + 1), '1, '1);
		send_request(3'(CMD_INCREMENT + 2), '0, '1);
		send_request(3'(CMD_INCREMENT + 3), '1, '0);
		// remove from the middle moves the last entry forward
		send_request(CMD_REMOVE,    '0, '0);
		send_request(CMD_GET,       64'h5555_5555_5555_5555, '0);
		// remove of a middle slot, of the front slot, then of the only entry left
		send_request(CMD_REMOVE,    64'h5555_5555_5555_5555, '0);
		send_request(CMD_REMOVE,    64'h0123_4567_89ab_cdef, '0);
		send_request(CMD_REMOVE,    '1, '0);
		send_request(CMD_GET,       '1, '0);
		go_idle(2);

		// random part: grow phases push the table to full and beyond, shrink
		// phases drain it; sender works in bursts with random gaps
		growing    = 1'b1;
		burst_left = $urandom_range(1, 12);
		for (int n = 0; n < 1400; n++) begin
			if (n % 150 == 0)
				growing = (n / 150) % 2 == 0;
			pick = $urandom_range(0, 99);
			if (growing) begin
				if (pick < 40)       cmd = CMD_SET;
				else if (pick < 65)  cmd = CMD_INCREMENT;
				else if (pick < 78)  cmd = CMD_GET;
				else if (pick < 88)  cmd = CMD_CONTAINS;
				else if (pick < 95)  cmd = CMD_REMOVE;
				else                 cmd = 3'(CMD_INCREMENT + $urandom_range(1, 3));
			end else begin
				if (pick < 40)       cmd = CMD_REMOVE;
				else if (pick < 55)  cmd = CMD_SET;
				else if (pick < 75)  cmd = CMD_GET;
				else if (pick < 88)  cmd = CMD_CONTAINS;
				else if (pick < 95)  cmd = CMD_INCREMENT;
				else                 cmd = 3'(CMD_INCREMENT + $urandom_range(1, 3));
			end
			// mostly pool keys so lookups hit; the rest are fresh keys
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, 95)];
			else
				k = rand64();
			case ($urandom_range(0, 7))
				0:       v = '0;
				1:       v = '1;
				2:       v = 64'(-$urandom_range(1, 16));
				default: v = rand64();
			endcase
			send_request(cmd, k, v);
			burst_left--;
			if (burst_left == 0) begin
				// long bursts now and then give stretches with no gaps
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
				go_idle($urandom_range(1, 90));
			end
		end
		start <= 1'b0;

		// drain, then stay quiet to catch stray strobes
		while (shadow.replies_due.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 16) @(posedge clk);

		if (shadow.replies_due.size() != 0)
			shadow.report_mismatch($sformatf("%0d replies never arrived",
				shadow.replies_due.size()));
		if (shadow.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
